[hdl/fpa_pkg.sv]
// Package with the types, opcodes and sizes shared by the fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW        = 32;
  localparam int MW        = 2 * DW;
  localparam int NW        = DW + FRAC_BITS;
  localparam int QSTEPS    = NW;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_EQ   = 4'd4,
    OP_NE   = 4'd5,
    OP_GT   = 4'd6,
    OP_LT   = 4'd7,
    OP_GE   = 4'd8,
    OP_LE   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13,
    OP_FINT = 4'd14,
    OP_TINT = 4'd15
  } op_t;

  typedef struct packed {
    logic            vld;
    logic            is_div;
    logic            neg;
    logic            dz;
    logic [NW-1:0]   rem;
    logic [NW-1:0]   quo;
    logic [DW-1:0]   dvs;
    logic [DW-1:0]   res;
    logic            flag;
  } cell_t;

endpackage

[hdl/fixed_point_alu_top.sv]
// Top level of the signed fixed-point ALU with its chain of division cells.
//
// Signed fixed-point ALU over 32-bit raw values with FRAC_BITS fraction bits. One beat is
// accepted every cycle while the output is empty or taken; each result passes through the
// front stage, the chain of one-bit division cells and the back stage. The whole pipeline
// advances together and holds when the output beat is not taken.
module fixed_point_alu_top
  import fpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [67:0] in_tdata,   // opcode[3:0], operand_a[35:4], operand_b[67:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_value[31:0], compare_flag[32], zero fill
);

  logic                 en;
  logic signed [DW-1:0] res;
  logic                 flag;
  cell_t                chain [QSTEPS+1];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  fpa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_tvalid),
    .opcode (in_tdata[3:0]),
    .a      (in_tdata[35:4]),
    .b      (in_tdata[67:36]),
    .cell_o (chain[0])
  );

  for (genvar i = 0; i < QSTEPS; i++) begin : g_cell
    fpa_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  fpa_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cell_i (chain[QSTEPS]),
    .vld_o  (out_tvalid),
    .res_o  (res),
    .flag_o (flag)
  );

  assign out_tdata = {7'd0, flag, res};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:0] == '0)
    else $error("comparison carried a nonzero value");

endmodule

[hdl/fpa_front.sv]
// Front stage: decodes the beat, computes every op but division and prepares div.
module fpa_front
  import fpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [3:0]           opcode,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  output cell_t                cell_o
);

  cell_t             cell_r, cell_nxt;
  logic [DW-1:0]     ma, mb;
  logic [MW-1:0]     prod;
  logic [MW-1:0]     prnd;
  logic [DW-1:0]     mres;
  logic              neg;

  always_comb begin
    ma   = a[DW-1] ? DW'(-a) : DW'(a);
    mb   = b[DW-1] ? DW'(-b) : DW'(b);
    neg  = a[DW-1] ^ b[DW-1];
    prod = ma * mb;
    prnd = (prod + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    mres = neg ? DW'(-prnd[DW-1:0]) : prnd[DW-1:0];
    cell_nxt        = '0;
    cell_nxt.vld    = in_vld;
    cell_nxt.neg    = neg;
    cell_nxt.dz     = (b == '0);
    cell_nxt.dvs    = mb;
    cell_nxt.quo    = NW'(ma) << FRAC_BITS;
    case (op_t'(opcode))
      OP_ADD:  cell_nxt.res = DW'(a + b);
      OP_SUB:  cell_nxt.res = DW'(a - b);
      OP_MUL:  cell_nxt.res = mres;
      OP_DIV:  cell_nxt.is_div = 1'b1;
      OP_EQ:   cell_nxt.flag = (a == b);
      OP_NE:   cell_nxt.flag = (a != b);
      OP_GT:   cell_nxt.flag = (a > b);
      OP_LT:   cell_nxt.flag = (a < b);
      OP_GE:   cell_nxt.flag = (a >= b);
      OP_LE:   cell_nxt.flag = (a <= b);
      OP_MIN:  cell_nxt.res = (a < b) ? a : b;
      OP_MAX:  cell_nxt.res = (a > b) ? a : b;
      OP_INC:  cell_nxt.res = DW'(a + 1);
      OP_DEC:  cell_nxt.res = DW'(a - 1);
      OP_FINT: cell_nxt.res = DW'(a <<< FRAC_BITS);
      OP_TINT: cell_nxt.res = DW'(a >>> FRAC_BITS);
      default: cell_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.is_div <= cell_nxt.is_div;
      cell_r.neg    <= cell_nxt.neg;
      cell_r.dz     <= cell_nxt.dz;
      cell_r.rem    <= cell_nxt.rem;
      cell_r.quo    <= cell_nxt.quo;
      cell_r.dvs    <= cell_nxt.dvs;
      cell_r.res    <= cell_nxt.res;
      cell_r.flag   <= cell_nxt.flag;
    end
  end

  assign cell_o = cell_r;

endmodule

[hdl/fpa_cell.sv]
// One restoring-division cell: retires one quotient bit and passes the beat on.
module fpa_cell
  import fpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t         cell_r, cell_nxt;
  logic [NW:0]   trial;
  logic [NW-1:0] shl;

  always_comb begin
    cell_nxt = cell_i;
    shl      = {cell_i.rem[NW-2:0], cell_i.quo[NW-1]};
    trial    = {1'b0, shl} - {{(NW-DW+1){1'b0}}, cell_i.dvs};
    cell_nxt.quo = {cell_i.quo[NW-2:0], ~trial[NW]};
    cell_nxt.rem = trial[NW] ? shl : trial[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.is_div <= cell_nxt.is_div;
      cell_r.neg    <= cell_nxt.neg;
      cell_r.dz     <= cell_nxt.dz;
      cell_r.rem    <= cell_nxt.rem;
      cell_r.quo    <= cell_nxt.quo;
      cell_r.dvs    <= cell_nxt.dvs;
      cell_r.res    <= cell_nxt.res;
      cell_r.flag   <= cell_nxt.flag;
    end
  end

  assign cell_o = cell_r;

endmodule

[hdl/fpa_back.sv]
// Back stage: rounds and signs the quotient and holds the result beat.
module fpa_back
  import fpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cell_t                 cell_i,
  output logic                  vld_o,
  output logic signed [DW-1:0]  res_o,
  output logic                  flag_o
);

  logic          vld_r;
  logic [DW-1:0] res_r, res_nxt;
  logic          flag_r;
  logic [NW:0]   r2;
  logic [NW-1:0] q;

  always_comb begin
    r2 = {cell_i.rem, 1'b0};
    q  = cell_i.quo + NW'(r2 >= {{(NW-DW+1){1'b0}}, cell_i.dvs});
    if (!cell_i.is_div) begin
      res_nxt = cell_i.res;
    end else if (cell_i.dz) begin
      res_nxt = '0;
    end else begin
      res_nxt = cell_i.neg ? DW'(-q[DW-1:0]) : q[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= cell_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      flag_r <= cell_i.flag;
    end
  end

  assign vld_o  = vld_r;
  assign res_o  = res_r;
  assign flag_o = flag_r;

endmodule
